>>> rtl/pet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types and constants for the pending event table.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int SIG_W   = 6;
  localparam int TIME_W  = 64;
  localparam int PEND_W  = 16;
  localparam int CMD_W   = 2;

  // depth of the queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SIG_W-1:0]  signal_number;
    logic [TIME_W-1:0] time_stamp;
    logic [PEND_W-1:0] amount;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [SIG_W-1:0]  found_signal;
    logic [TIME_W-1:0] found_time;
    logic [PEND_W-1:0] found_pending;
  } out_word_t;

  // a classified command on its way to the back end
  typedef struct packed {
    logic [CMD_W-1:0]  kind;
    logic [SIG_W-1:0]  sig;
    logic [TIME_W-1:0] ts;
    logic [PEND_W-1:0] amt;
  } op_t;

endpackage
`default_nettype wire

>>> rtl/pending_event_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pending_event_table
// Table of event kinds with timestamps and pending counts: record, query
// and mark-seen commands.
// ----------------------------------------------------------------------------
// a query scans every slot and registers its result at the last one; record
// and mark-seen stop at the slot that settles them. One command is handled at
// a time, one slot per cycle, holding on a query's last slot while the result
// register is full; a two-deep queue buffers words meanwhile
// reset: synchronous, clears all slot kinds and counts in the same cycle
// ----------------------------------------------------------------------------
module pending_event_table (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire pet_pkg::in_word_t  in_word,
  output logic                    empty,
  input  wire logic               pop,
  output pet_pkg::out_word_t      out_word
);

  logic         q_push, q_full, q_pop, q_empty;
  pet_pkg::op_t q_in_op, q_out_op;

  pet_front u_front (
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_op    (q_in_op)
  );

  pet_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_push),
    .wr_op (q_in_op),
    .full  (q_full),
    .rd_en (q_pop),
    .rd_op (q_out_op),
    .empty (q_empty)
  );

  pet_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_op     (q_out_op),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

>>> rtl/pet_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pet_front
// Accepts input words, drops those with no effect and forwards the rest.
// ----------------------------------------------------------------------------
module pet_front (
  input  wire logic              push,
  output logic                   full,
  input  wire pet_pkg::in_word_t in_word,
  output logic                   q_push,
  input  wire logic              q_full,
  output pet_pkg::op_t           q_op
);

  logic keep;

  always_comb begin
    unique case (in_word.cmd) inside
      pet_pkg::CMD_RECORD, pet_pkg::CMD_MARK: keep = (in_word.signal_number != '0);
      pet_pkg::CMD_QUERY:                     keep = 1'b1;
      default:                                keep = 1'b0;
    endcase
  end

  // dropped words are taken at once but still respect back-pressure
  assign full        = q_full;
  assign q_push      = push && !q_full && keep;
  assign q_op.kind   = in_word.cmd;
  assign q_op.sig    = in_word.signal_number;
  assign q_op.ts     = in_word.time_stamp;
  assign q_op.amt    = in_word.amount;

endmodule
`default_nettype wire

>>> rtl/pet_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pet_fifo
// Short command queue decoupling the front end from the table scanner.
// ----------------------------------------------------------------------------
module pet_fifo (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire pet_pkg::op_t wr_op,
  output logic              full,
  input  wire logic         rd_en,
  output pet_pkg::op_t      rd_op,
  output logic              empty
);

  pet_pkg::op_t                  mem_r [pet_pkg::Q_DEPTH];
  logic [pet_pkg::QPTR_W-1:0]    wptr_r, wptr_nxt;
  logic [pet_pkg::QPTR_W-1:0]    rptr_r, rptr_nxt;
  logic [pet_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          do_wr, do_rd;

  localparam logic [pet_pkg::QPTR_W-1:0] PTR_LAST = pet_pkg::QPTR_W'(pet_pkg::Q_DEPTH - 1);
  localparam logic [pet_pkg::QCNT_W-1:0] CNT_FULL = pet_pkg::QCNT_W'(pet_pkg::Q_DEPTH);

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_op = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_op;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pet_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pet_back
// Slot table and scanner: visits one slot a cycle to record, mark or query; queries stall on a full output.
// ----------------------------------------------------------------------------
module pet_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pet_pkg::op_t  q_op,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               empty,
  input  wire logic          pop,
  output pet_pkg::out_word_t out_word
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;
  localparam logic [pet_pkg::IDX_W-1:0] IDX_LAST = pet_pkg::IDX_W'(pet_pkg::SLOTS - 1);

  logic [pet_pkg::SIG_W-1:0]  sig_r  [pet_pkg::SLOTS];
  logic [pet_pkg::PEND_W-1:0] pend_r [pet_pkg::SLOTS];
  logic [pet_pkg::TIME_W-1:0] time_r [pet_pkg::SLOTS];

  logic                       state_r, state_nxt;
  logic [pet_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  pet_pkg::op_t               op_r;

  logic                       best_vld_r, best_vld_nxt;
  logic [pet_pkg::SIG_W-1:0]  best_sig_r;
  logic [pet_pkg::TIME_W-1:0] best_time_r;
  logic [pet_pkg::PEND_W-1:0] best_pend_r;
  logic                       best_load;

  logic                       out_vld_r, out_vld_nxt;
  pet_pkg::out_word_t         out_word_r;
  logic                       out_load;
  pet_pkg::out_word_t         res_word;

  logic [pet_pkg::SIG_W-1:0]  cur_sig;
  logic [pet_pkg::PEND_W-1:0] cur_pend;
  logic [pet_pkg::TIME_W-1:0] cur_time;
  logic                       hit, last, qualify, better, take_cur, out_free;
  logic                       wr_en, wr_time;
  logic [pet_pkg::PEND_W-1:0] wr_pend;
  logic [pet_pkg::PEND_W:0]   sum;

  // wrapping signed difference a - b is strictly positive
  function automatic logic later_than(input logic [pet_pkg::TIME_W-1:0] a,
                                      input logic [pet_pkg::TIME_W-1:0] b);
    logic [pet_pkg::TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[pet_pkg::TIME_W-1];
  endfunction

  assign cur_sig  = sig_r[idx_r];
  assign cur_pend = pend_r[idx_r];
  assign cur_time = time_r[idx_r];
  assign hit      = (cur_sig == op_r.sig);
  assign last     = (idx_r == IDX_LAST);
  assign qualify  = (cur_pend != '0) && ((op_r.ts == '0) || later_than(cur_time, op_r.ts));
  assign better   = !best_vld_r || later_than(best_time_r, cur_time);
  assign take_cur = qualify && better;
  assign out_free = !out_vld_r || pop;
  assign sum      = {1'b0, cur_pend} + {1'b0, op_r.amt};

  always_comb begin
    res_word = '0;
    if (take_cur) begin
      res_word.found         = 1'b1;
      res_word.found_signal  = cur_sig;
      res_word.found_time    = cur_time;
      res_word.found_pending = cur_pend;
    end else if (best_vld_r) begin
      res_word.found         = 1'b1;
      res_word.found_signal  = best_sig_r;
      res_word.found_time    = best_time_r;
      res_word.found_pending = best_pend_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    q_pop        = 1'b0;
    wr_en        = 1'b0;
    wr_time      = 1'b0;
    wr_pend      = cur_pend;
    best_load    = 1'b0;
    best_vld_nxt = best_vld_r;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          idx_nxt      = '0;
          best_vld_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        case (op_r.kind)
          pet_pkg::CMD_RECORD: begin
            // claim the first matching or empty slot, the last one when full
            if (hit || (cur_sig == '0) || last) begin
              wr_en     = 1'b1;
              wr_time   = 1'b1;
              wr_pend   = hit ? (sum[pet_pkg::PEND_W] ? '1 : sum[pet_pkg::PEND_W-1:0])
                              : op_r.amt;
              state_nxt = ST_IDLE;
            end
          end
          pet_pkg::CMD_MARK: begin
            if (hit) begin
              wr_en   = 1'b1;
              wr_pend = (cur_pend > op_r.amt) ? cur_pend - op_r.amt : '0;
            end
            if (hit || last) begin
              state_nxt = ST_IDLE;
            end
          end
          pet_pkg::CMD_QUERY: begin
            if (last) begin
              // hold on the last slot until the result register frees up
              if (out_free) begin
                out_load  = 1'b1;
                state_nxt = ST_IDLE;
              end else begin
                idx_nxt = idx_r;
              end
            end else if (take_cur) begin
              best_load    = 1'b1;
              best_vld_nxt = 1'b1;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      best_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      best_vld_r <= best_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_op;
    end
    if (best_load) begin
      best_sig_r  <= cur_sig;
      best_time_r <= cur_time;
      best_pend_r <= cur_pend;
    end
    if (out_load) begin
      out_word_r <= res_word;
    end
    if (wr_time) begin
      time_r[idx_r] <= op_r.ts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pet_pkg::SLOTS; i++) begin
        sig_r[i]  <= '0;
        pend_r[i] <= '0;
      end
    end else if (wr_en) begin
      sig_r[idx_r]  <= op_r.sig;
      pend_r[idx_r] <= wr_pend;
    end
  end

  assign empty    = !out_vld_r;
  assign out_word = out_word_r;

endmodule
`default_nettype wire

>>> sim/tb_pending_event_table.sv
// ----------------------------------------------------------------------------
// tb_pending_event_table
// Self-checking bench for the pending event table: a short table of directed
// words, then random record, query, mark-seen and unused-command traffic with
// random stalls on both queue ports. An internal model of the slots predicts the
// query answers the table does not fix; all are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_pending_event_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 1750;
  localparam int DRAIN_CYC  = 2 * (pet_pkg::SLOTS + 3);
  localparam int STALL_LIMIT = 5000;
  localparam int SHOW_MAX   = 10;

  typedef struct {
    pet_pkg::in_word_t  w;
    bit                 typed;
    pet_pkg::out_word_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  pet_pkg::in_word_t  in_word = '0;
  logic               full;
  logic               empty;
  pet_pkg::out_word_t out_word;

  // model of the slots
  logic [pet_pkg::SIG_W-1:0]  ev_kind  [pet_pkg::SLOTS];
  logic [pet_pkg::TIME_W-1:0] ev_time  [pet_pkg::SLOTS];
  logic [pet_pkg::PEND_W-1:0] ev_count [pet_pkg::SLOTS];

  pet_pkg::out_word_t expected_finds[$];
  dir_row_t           dir_rows[$];
  int                 err_count = 0;
  bit                 idle_on = 1'b1;
  logic [63:0]        now_time = 64'd1000;
  int                 kind_hi = 10;

  pending_event_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // a is later than b by wrapping signed difference
  function automatic bit is_later(logic [pet_pkg::TIME_W-1:0] a,
                                  logic [pet_pkg::TIME_W-1:0] b);
    logic [pet_pkg::TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[pet_pkg::TIME_W-1];
  endfunction

  task automatic predict_event_table(input pet_pkg::in_word_t w, output bit has_find,
                                     output pet_pkg::out_word_t find);
    int          i;
    int          best;
    logic [16:0] sum;
    has_find = 1'b0;
    find     = '0;
    best     = -1;
    case (w.cmd)
      pet_pkg::CMD_RECORD: begin
        if (w.signal_number != '0) begin
          i = 0;
          while (i < pet_pkg::SLOTS - 1 && ev_kind[i] != '0 &&
                 ev_kind[i] != w.signal_number)
            i++;
          if (ev_kind[i] == w.signal_number) begin
            sum = {1'b0, ev_count[i]} + {1'b0, w.amount};
            ev_count[i] = sum[16] ? 16'hFFFF : sum[15:0];
          end else begin
            ev_kind[i]  = w.signal_number;
            ev_count[i] = w.amount;
          end
          ev_time[i] = w.time_stamp;
        end
      end
      pet_pkg::CMD_MARK: begin
        if (w.signal_number != '0) begin
          i = 0;
          while (i < pet_pkg::SLOTS && ev_kind[i] != w.signal_number)
            i++;
          if (i < pet_pkg::SLOTS)
            ev_count[i] = (ev_count[i] > w.amount) ? ev_count[i] - w.amount : '0;
        end
      end
      pet_pkg::CMD_QUERY: begin
        has_find = 1'b1;
        for (i = 0; i < pet_pkg::SLOTS; i++) begin
          if (ev_count[i] != '0 &&
              (w.time_stamp == '0 || is_later(ev_time[i], w.time_stamp))) begin
            if (best < 0)
              best = i;
            else if (is_later(ev_time[best], ev_time[i]))
              best = i;
          end
        end
        if (best >= 0) begin
          find.found         = 1'b1;
          find.found_signal  = ev_kind[best];
          find.found_time    = ev_time[best];
          find.found_pending = ev_count[best];
        end
      end
      default: ;
    endcase
  endtask

  function automatic pet_pkg::in_word_t word_of(logic [pet_pkg::CMD_W-1:0] c,
                                                logic [pet_pkg::SIG_W-1:0] s,
                                                logic [pet_pkg::TIME_W-1:0] t,
                                                logic [pet_pkg::PEND_W-1:0] a);
    pet_pkg::in_word_t w;
    w.cmd           = c;
    w.signal_number = s;
    w.time_stamp    = t;
    w.amount        = a;
    return w;
  endfunction

  function automatic void add_row(pet_pkg::in_word_t w, bit typed,
                                  pet_pkg::out_word_t want);
    dir_row_t r;
    r.w     = w;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic pet_pkg::in_word_t random_word();
    pet_pkg::in_word_t w;
    int                r;
    r = $urandom_range(99);
    w.cmd = (r < 40) ? pet_pkg::CMD_RECORD : (r < 70) ? pet_pkg::CMD_QUERY :
            (r < 95) ? pet_pkg::CMD_MARK : pet_pkg::CMD_UNUSED;
    w.signal_number = ($urandom_range(19) == 0) ?
                      pet_pkg::SIG_W'($urandom_range(63)) :
                      pet_pkg::SIG_W'($urandom_range(kind_hi, 1));
    r = $urandom_range(99);
    if (r < 2)
      now_time = rand64();
    else
      now_time = now_time + 64'($urandom_range(1000, 1));
    if (w.cmd == pet_pkg::CMD_QUERY) begin
      r = $urandom_range(99);
      if (r < 30)
        w.time_stamp = '0;
      else if (r < 70)
        w.time_stamp = now_time - 64'($urandom_range(3000));
      else if (r < 90)
        w.time_stamp = rand64();
      else
        w.time_stamp = now_time;
    end else begin
      r = $urandom_range(99);
      if (r < 90)
        w.time_stamp = now_time;
      else if (r < 95)
        w.time_stamp = rand64();
      else
        w.time_stamp = now_time - 64'($urandom_range(2000));
    end
    r = $urandom_range(99);
    if (r < 60)
      w.amount = pet_pkg::PEND_W'($urandom_range(5, 1));
    else if (r < 70)
      w.amount = '0;
    else if (r < 80)
      w.amount = '1;
    else
      w.amount = pet_pkg::PEND_W'($urandom_range(65535));
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input pet_pkg::in_word_t w, input bit typed,
                           input pet_pkg::out_word_t want);
    bit                 has_find;
    pet_pkg::out_word_t find;
    if (idle_on) begin
      while ($urandom_range(99) < 32) begin
        push <= 1'b0;
        @(negedge clk);
      end
    end
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full !== 1'b0);
    predict_event_table(w, has_find, find);
    if (has_find)
      expected_finds.push_back(typed ? want : find);
    @(negedge clk);
  endtask

  function automatic void report(string what, pet_pkg::out_word_t want,
                                 pet_pkg::out_word_t got);
    err_count++;
    if (err_count <= SHOW_MAX)
      $display("%0t: %s: expected %0b/%0d/%h/%0d got %0b/%0d/%h/%0d", $realtime, what,
               want.found, want.found_signal, want.found_time, want.found_pending,
               got.found, got.found_signal, got.found_time, got.found_pending);
  endfunction

  // result side: check at the rising edge, change pop at the falling edge
  initial begin
    pet_pkg::out_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n && pop && empty === 1'b0) begin
        if (expected_finds.size() == 0) begin
          report("unexpected word", '0, out_word);
        end else begin
          want = expected_finds.pop_front();
          if (out_word.found !== want.found || out_word.found_signal !== want.found_signal ||
              out_word.found_time !== want.found_time ||
              out_word.found_pending !== want.found_pending)
            report("mismatch", want, out_word);
        end
      end
      @(negedge clk);
      if (rst_n)
        pop <= !idle_on || ($urandom_range(99) >= 32);
    end
  end

  // watchdog on cycles where neither port moves a word
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && full === 1'b0) || (pop && empty === 1'b0) || !rst_n)
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    pet_pkg::out_word_t no_find;
    pet_pkg::out_word_t top_63;
    pet_pkg::in_word_t  w;
    int                 n_sent;
    no_find              = '0;
    top_63.found         = 1'b1;
    top_63.found_signal  = 6'd63;
    top_63.found_time    = '1;
    top_63.found_pending = '1;
    for (int i = 0; i < pet_pkg::SLOTS; i++) begin
      ev_kind[i]  = '0;
      ev_time[i]  = '0;
      ev_count[i] = '0;
    end

    add_row(word_of(pet_pkg::CMD_QUERY,  6'd0,  64'd0, 16'd0), 1'b1, no_find);
    add_row(word_of(pet_pkg::CMD_RECORD, 6'd0,  64'd5, 16'd3), 1'b0, no_find); // kind zero
    add_row(word_of(pet_pkg::CMD_QUERY,  6'd0,  64'd0, 16'd0), 1'b1, no_find);
    add_row(word_of(pet_pkg::CMD_UNUSED, 6'd5,  64'd1, 16'd1), 1'b0, no_find);
    add_row(word_of(pet_pkg::CMD_RECORD, 6'd63, '1, '1), 1'b0, no_find);
    add_row(word_of(pet_pkg::CMD_RECORD, 6'd63, '1, 16'd1), 1'b0, no_find);    // saturates
    add_row(word_of(pet_pkg::CMD_QUERY,  6'd0,  64'd0, 16'd0), 1'b1, top_63);
    add_row(word_of(pet_pkg::CMD_MARK,   6'd9,  64'd0, 16'd1), 1'b0, no_find); // unknown kind
    add_row(word_of(pet_pkg::CMD_MARK,   6'd0,  64'd0, 16'd5), 1'b0, no_find);
    add_row(word_of(pet_pkg::CMD_MARK,   6'd63, 64'd0, '1), 1'b0, no_find);    // clamps at zero
    add_row(word_of(pet_pkg::CMD_QUERY,  6'd0,  64'd0, 16'd0), 1'b1, no_find);
    add_row(word_of(pet_pkg::CMD_RECORD, 6'd1,  64'd100, 16'd0), 1'b0, no_find);
    add_row(word_of(pet_pkg::CMD_QUERY,  6'd0,  64'd0, 16'd0), 1'b1, no_find);
    add_row(word_of(pet_pkg::CMD_RECORD, 6'd2,  64'h7FFF_FFFF_FFFF_FFF0, 16'd2), 1'b0,
            no_find);
    add_row(word_of(pet_pkg::CMD_RECORD, 6'd3,  64'h8000_0000_0000_0010, 16'd4), 1'b0,
            no_find);
    add_row(word_of(pet_pkg::CMD_QUERY,  6'd0,  64'h7FFF_FFFF_FFFF_FFFF, 16'd0), 1'b0,
            no_find);
    add_row(word_of(pet_pkg::CMD_QUERY,  6'd0,  64'd0, 16'd0), 1'b0, no_find);
    add_row(word_of(pet_pkg::CMD_RECORD, 6'd1,  64'd0, 16'd7), 1'b0, no_find);
    add_row(word_of(pet_pkg::CMD_QUERY,  6'd0,  64'd1, 16'd0), 1'b0, no_find);
    add_row(word_of(pet_pkg::CMD_MARK,   6'd2,  64'd0, 16'd1), 1'b0, no_find);
    add_row(word_of(pet_pkg::CMD_QUERY,  6'd0,  64'd0, 16'd0), 1'b0, no_find);
    add_row(word_of(pet_pkg::CMD_RECORD, 6'd3,  64'd5, 16'd0), 1'b0, no_find);
    add_row(word_of(pet_pkg::CMD_QUERY,  6'd0,  64'h8000_0000_0000_0000, 16'd0), 1'b0,
            no_find);
    add_row(word_of(pet_pkg::CMD_QUERY,  6'd42, '1, '1), 1'b0, no_find);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

    // narrow kinds first so the scan meets empty slots, then enough kinds
    // to fill the slots and keep replacing the last one, then twenty kinds
    n_sent = 0;
    while (n_sent < N_RANDOM) begin
      kind_hi = (n_sent < 500) ? 10 : (n_sent < 1000) ? 63 : 20;
      idle_on = !(n_sent >= 900 && n_sent < 1250);
      w = random_word();
      send_word(w, 1'b0, no_find);
      n_sent++;
    end
    idle_on = 1'b1;
    push <= 1'b0;

    while (expected_finds.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
rtl/pet_pkg.sv
rtl/pet_front.sv
rtl/pet_fifo.sv
rtl/pet_back.sv
rtl/pending_event_table.sv
sim/tb_pending_event_table.sv
